@@ rtl/eeg_pkg.sv @@
// ----------------------------------------------------------------------------
// eeg_pkg
// Shared types for the extended Euclid GCD core: the sequencer's control
// strobes and the datapath status.
// ----------------------------------------------------------------------------
package eeg_pkg;

	// Control strobes from the sequencer to the datapath
	typedef struct packed {
		logic load;     // take a new request into the remainder pair
		logic div_init; // set up the quotient/remainder pass
		logic div_step; // one restoring-division bit
		logic update;   // rotate remainders and coefficients
	} eeg_ctrl_t;

	// Status from the datapath back to the sequencer
	typedef struct packed {
		logic rem_zero; // current remainder is zero: result is ready
	} eeg_stat_t;

endpackage

@@ rtl/eeg_if.sv @@
// ----------------------------------------------------------------------------
// eeg_req_if / eeg_rsp_if
// Valid/ready channels for the extended Euclid GCD core: operand requests
// in, divisor and Bezout coefficients out.
// ----------------------------------------------------------------------------
interface eeg_req_if #(
	parameter int unsigned OPERAND_WIDTH = 32
);
	logic                     valid;
	logic                     ready;
	logic [OPERAND_WIDTH-1:0] operand_a;
	logic [OPERAND_WIDTH-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface eeg_rsp_if #(
	parameter int unsigned OPERAND_WIDTH = 32
);
	logic                     valid;
	logic                     ready;
	logic [OPERAND_WIDTH-1:0] divisor;
	logic signed [OPERAND_WIDTH:0] coef_a;
	logic signed [OPERAND_WIDTH:0] coef_b;

	modport source (output valid, output divisor, output coef_a, output coef_b,
		input ready);
	modport sink   (input valid, input divisor, input coef_a, input coef_b,
		output ready);
endinterface

@@ rtl/extended_euclid_gcd_core.sv @@
// ----------------------------------------------------------------------------
// extended_euclid_gcd_core
// Extended Euclid: gcd of two unsigned operands and their Bezout coefficients.
// ----------------------------------------------------------------------------
// One request (operand_a, operand_b) gives one response with
// divisor = gcd(a, b) and signed coefficients coef_a, coef_b such that
// a*coef_a + b*coef_b = divisor. A zero operand a gives divisor b, coef_a 0,
// coef_b 1; a zero operand b (a nonzero) gives divisor a, coef_a 1, coef_b 0.
// The core runs forward Euclid on the pair (b, a). Each Euclid step is one
// pass of a shared restoring divider, one quotient bit per cycle, which also
// builds quotient times coefficient on the fly. The core takes one request
// at a time; a finished response sits in an output register, so the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_core
	import eeg_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	eeg_req_if.sink    req,
	eeg_rsp_if.source  rsp
);

	localparam int unsigned W     = OPERAND_WIDTH;
	localparam int unsigned CNT_W = $clog2(W);

	typedef enum logic [1:0] {
		S_IDLE, // waiting for a request
		S_TEST, // check remainder, start a division pass or finish
		S_DIV,  // one quotient bit per cycle
		S_UPD   // rotate remainders and coefficients
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	eeg_ctrl_t ctrl;
	eeg_stat_t stat;

	logic [W-1:0] dp_divisor;
	logic [W:0]   dp_coef_a, dp_coef_b;

	// response register
	logic         out_valid_q;
	logic [W-1:0] divisor_q;
	logic [W:0]   coef_a_q, coef_b_q;

	logic         out_free;
	logic         finish;

	assign out_free = !out_valid_q || rsp.ready;
	// done when the remainder reached zero and the response slot can take it
	assign finish   = (state_q == S_TEST) && stat.rem_zero && out_free;

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		ctrl.load     = req.valid && req.ready;
		ctrl.div_init = (state_q == S_TEST) && !stat.rem_zero;
		ctrl.div_step = (state_q == S_DIV);
		ctrl.update   = (state_q == S_UPD);
	end

	eeg_datapath #(
		.OPERAND_WIDTH (W)
	) u_datapath (
		.clk       (clk),
		.ctrl      (ctrl),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.stat      (stat),
		.divisor   (dp_divisor),
		.coef_a    (dp_coef_a),
		.coef_b    (dp_coef_b)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					if (!stat.rem_zero) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(W-1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_TEST;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (finish) begin
			divisor_q <= dp_divisor;
			coef_a_q  <= dp_coef_a;
			coef_b_q  <= dp_coef_b;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.divisor = divisor_q;
	assign rsp.coef_a  = coef_a_q;
	assign rsp.coef_b  = coef_b_q;

endmodule

@@ rtl/eeg_datapath.sv @@
// ----------------------------------------------------------------------------
// eeg_datapath
// Remainder pair, coefficient pairs and the shared restoring-division step
// that also accumulates quotient times coefficient, MSB first.
// ----------------------------------------------------------------------------
module eeg_datapath
	import eeg_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic                     clk,
	input  eeg_ctrl_t                ctrl,
	input  logic [OPERAND_WIDTH-1:0] operand_a,
	input  logic [OPERAND_WIDTH-1:0] operand_b,
	output eeg_stat_t                stat,
	output logic [OPERAND_WIDTH-1:0] divisor,
	output logic [OPERAND_WIDTH:0]   coef_a,
	output logic [OPERAND_WIDTH:0]   coef_b
);

	localparam int unsigned W = OPERAND_WIDTH;

	// remainders: previous and current
	logic [W-1:0] rp_q, rc_q;
	// coefficients of a and of b, previous and current (mod 2^(W+1))
	logic [W:0]   cap_q, cac_q, cbp_q, cbc_q;
	// division pass: partial remainder, dividend shifter, q*c accumulators
	logic [W-1:0] rem_q, nq_q;
	logic [W:0]   pa_q, pb_q;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;

	// one restoring step: bring down the next dividend bit, try subtract
	always_comb begin
		trial = {rem_q, nq_q[W-1]};
		diff  = trial - {1'b0, rc_q};
		ge    = (trial >= {1'b0, rc_q});
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rp_q  <= operand_b;
			rc_q  <= operand_a;
			cbp_q <= (W+1)'(1);
			cbc_q <= '0;
			cap_q <= '0;
			cac_q <= (W+1)'(1);
		end else if (ctrl.update) begin
			rp_q  <= rc_q;
			rc_q  <= rem_q;
			cap_q <= cac_q;
			cac_q <= cap_q - pa_q;
			cbp_q <= cbc_q;
			cbc_q <= cbp_q - pb_q;
		end

		if (ctrl.div_init) begin
			rem_q <= '0;
			nq_q  <= rp_q;
			pa_q  <= '0;
			pb_q  <= '0;
		end else if (ctrl.div_step) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			nq_q  <= {nq_q[W-2:0], 1'b0};
			// Horner form of q*c: shift, add c when the quotient bit is set
			pa_q  <= {pa_q[W-1:0], 1'b0} + (ge ? cac_q : '0);
			pb_q  <= {pb_q[W-1:0], 1'b0} + (ge ? cbc_q : '0);
		end
	end

	assign stat.rem_zero = (rc_q == '0);
	assign divisor       = rp_q;
	assign coef_a        = cap_q;
	assign coef_b        = cbp_q;

endmodule
